[hw/rtl/lpsd_pkg.sv]
// Shared constants and types for the length-prefixed stream deframer.
package lpsd_pkg;

    // Header layout, byte offsets within a frame header
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] HEADER_BYTES = 5'd22;
    localparam logic [POS_W-1:0] SRC_PORT_AT  = 5'd8;
    localparam logic [POS_W-1:0] DST_ID_AT    = 5'd10;
    localparam logic [POS_W-1:0] DST_PORT_AT  = 5'd18;
    localparam logic [POS_W-1:0] LENGTH_AT    = 5'd20;

    // Default depth of the queue between parser and output stage
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // One payload beat with the header fields of its frame
    typedef struct packed {
        logic [63:0] source_id;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        frame_end;
    } t_beat;

    // Push side of the queue
    typedef struct packed {
        logic  valid;
        t_beat beat;
    } t_push;

    // Queue status seen by the parser and the output stage
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hw/rtl/lpsd_front.sv]
// Header parser: collects header fields and classifies each byte.
module lpsd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    output lpsd_pkg::t_push   o_push
);

    logic [lpsd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [63:0] r_src_id, n_src_id;
    logic [15:0] r_src_port, n_src_port;
    logic [15:0] r_dst_port, n_dst_port;
    logic [15:0] r_len, n_len;
    logic [15:0] r_left, n_left;
    logic        in_payload;
    logic        last;

    assign in_payload = (r_pos == lpsd_pkg::HEADER_BYTES);
    assign last       = (r_left <= 16'd1);

    // Walk the header, then count down the payload
    always_comb begin
        n_pos      = r_pos;
        n_src_id   = r_src_id;
        n_src_port = r_src_port;
        n_dst_port = r_dst_port;
        n_len      = r_len;
        n_left     = r_left;
        if (i_accept) begin
            if (!in_payload) begin
                if (r_pos < lpsd_pkg::SRC_PORT_AT) begin
                    n_src_id = {r_src_id[55:0], i_data_byte};
                end else if (r_pos < lpsd_pkg::DST_ID_AT) begin
                    n_src_port = {r_src_port[7:0], i_data_byte};
                end else if (r_pos < lpsd_pkg::DST_PORT_AT) begin
                    // destination id: drop
                    n_src_id = r_src_id;
                end else if (r_pos < lpsd_pkg::LENGTH_AT) begin
                    n_dst_port = {r_dst_port[7:0], i_data_byte};
                end else begin
                    n_len = {r_len[7:0], i_data_byte};
                end
                if (r_pos == lpsd_pkg::HEADER_BYTES - 5'd1) begin
                    // keepalive frames go straight back to a new header
                    if (n_len == 16'd0) begin
                        n_pos = '0;
                    end else begin
                        n_left = n_len;
                        n_pos  = lpsd_pkg::HEADER_BYTES;
                    end
                end else begin
                    n_pos = r_pos + 5'd1;
                end
            end else begin
                if (last) begin
                    n_left = '0;
                    n_pos  = '0;
                end else begin
                    n_left = r_left - 16'd1;
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_left     <= '0;
            r_src_id   <= '0;
            r_src_port <= '0;
            r_dst_port <= '0;
            r_len      <= '0;
        end else begin
            r_pos      <= n_pos;
            r_left     <= n_left;
            r_src_id   <= n_src_id;
            r_src_port <= n_src_port;
            r_dst_port <= n_dst_port;
            r_len      <= n_len;
        end
    end

    // Emit a beat for every payload byte
    always_comb begin
        o_push.valid               = i_accept && in_payload;
        o_push.beat.source_id      = r_src_id;
        o_push.beat.source_port    = r_src_port;
        o_push.beat.dest_port      = r_dst_port;
        o_push.beat.payload_length = r_len;
        o_push.beat.payload_byte   = i_data_byte;
        o_push.beat.frame_end      = last;
    end

endmodule

[hw/rtl/lpsd_queue.sv]
// Short FIFO of payload beats between parser and output stage.
module lpsd_queue #(
    parameter int unsigned QUEUE_DEPTH = lpsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpsd_pkg::t_push     i_push,
    input  logic                i_pop,
    output lpsd_pkg::t_beat     o_head,
    output lpsd_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    lpsd_pkg::t_beat r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push.valid && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.beat;
        end
    end

endmodule

[hw/rtl/lpsd_back.sv]
// Output register stage: presents queued beats to the receiver.
module lpsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpsd_pkg::t_beat     i_head,
    input  lpsd_pkg::t_q_status i_status,
    input  logic                i_stall,
    output logic                o_pop,
    output logic                o_valid,
    output lpsd_pkg::t_beat     o_beat
);

    logic            r_valid;
    lpsd_pkg::t_beat r_beat;

    // Load when the register is empty or its beat is being taken
    assign o_pop   = !i_status.empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_beat <= i_head;
        end
    end

endmodule

[hw/rtl/length_prefixed_stream_deframer_unit.sv]
// Top level of the length-prefixed stream deframer.
//
// Input channel: one raw stream byte per beat (i_valid, i_data_byte, o_stall).
// Output channel: one payload byte per beat with the frame's source id,
// source port, destination port and payload length, and o_frame_end on the
// last byte of a frame (o_valid, i_stall).
// Each frame is a 22-byte header followed by payload_length bytes; header
// bytes and zero-length keepalive frames produce no output beats.
// Throughput: one byte per cycle on both channels while neither side stalls;
// the header/payload counters in the parser advance on every accepted byte.
// A payload byte is written to the queue at the edge that accepts it; once
// it is at the head of the queue and the output register is empty or its
// beat is being taken, it moves into the output register and is presented.
// When the receiver stalls, the output register holds its beat and further
// beats collect in the queue (QUEUE_DEPTH entries); once it is full, o_stall
// rises and input beats are held off. The parser keeps running while the
// queue has room, so a new header can be parsed during a stall.
// Reset (synchronous, active low) empties the queue and output register and
// restarts the parser at the first byte of a header.
module length_prefixed_stream_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = lpsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_source_id,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [15:0] o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_end
);

    lpsd_pkg::t_push     push;
    lpsd_pkg::t_beat     head;
    lpsd_pkg::t_beat     out_beat;
    lpsd_pkg::t_q_status q_status;
    logic                accept;
    logic                pop;

    // Take an input beat whenever the queue has room
    assign o_stall = q_status.full;
    assign accept  = i_valid && !o_stall;

    lpsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_push      (push)
    );

    lpsd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    lpsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_status),
        .i_stall  (i_stall),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_beat   (out_beat)
    );

    // Break out the output beat
    assign o_source_id      = out_beat.source_id;
    assign o_source_port    = out_beat.source_port;
    assign o_dest_port      = out_beat.dest_port;
    assign o_payload_length = out_beat.payload_length;
    assign o_payload_byte   = out_beat.payload_byte;
    assign o_frame_end      = out_beat.frame_end;

endmodule

[hw/rtl/lpsd_checker.sv]
// Port-level checks for the deframer, bound to the top level.
module lpsd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [63:0] o_source_id,
    input  logic [15:0] o_source_port,
    input  logic [15:0] o_dest_port,
    input  logic [15:0] o_payload_length,
    input  logic [7:0]  o_payload_byte,
    input  logic        o_frame_end
);

    // Nothing is presented in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte)
            && $stable(o_frame_end) && $stable(o_source_id)
            && $stable(o_source_port) && $stable(o_dest_port)
            && $stable(o_payload_length))
        else $error("stalled output beat changed");

    // Keepalive frames never reach the output
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_payload_length != 16'd0)
        else $error("output beat from a zero-length frame");

    // A one-byte frame ends on its only byte
    a_single_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_payload_length == 16'd1 |-> o_frame_end)
        else $error("one-byte frame without frame end");

    // Within a frame, taken beats are followed by beats with the same source id and payload length
    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_frame_end ##1 o_valid |->
            $stable(o_source_id) && $stable(o_payload_length))
        else $error("header fields changed inside a frame");

endmodule

bind length_prefixed_stream_deframer_unit lpsd_checker u_lpsd_checker (.*);
